### design/dkph_pkg.sv
`timescale 1ns / 1ps

package dkph_pkg;

    localparam int KEY_W     = 16;
    localparam int BUCKET_W  = 16;
    localparam int MULT_W    = 16;
    localparam int TSIZE_W   = 15;
    localparam int HASH_W    = 32;
    localparam int MAG_W     = 17;
    localparam int DIGIT_W   = 4;
    localparam int NUM_DIGITS = 5;
    localparam int DIG_IDX_W = 3;
    localparam int DIV_CNT_W = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int CHAR_W    = 8;

    localparam logic [MULT_W-1:0] DIV10_RECIP = 16'hCCCD;
    localparam int                DIV10_SHIFT = 19;

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

    localparam logic [CFG_IDX_W-1:0] CFG_MULTIPLIER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = 2'd1;

    localparam logic [MULT_W-1:0]  MULT_RESET  = 16'd31;
    localparam logic [TSIZE_W-1:0] TSIZE_RESET = 15'd16;

endpackage

### design/decimal_key_polynomial_hash.sv
`timescale 1ns / 1ps
// a key of d = 1..5 digits is split into decimal digits, folded into the hash and then reduced
// modulo the table size; one 32x16 multiplier serves digit split and hash fold,
// and a 1-bit-per-cycle restoring divider forms the remainder
// one key at a time: a new key is taken only in idle, after the last result has been
// moved to the output register; a new key is taken while a result waits
// reset: aresetn synchronous active low, returns to idle, multiplier 31, table size 16
module decimal_key_polynomial_hash (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [dkph_pkg::KEY_W-1:0]         s_tdata,   // key_id
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [dkph_pkg::BUCKET_W-1:0]      m_tdata,   // bucket_index
    input  logic                               cfg_wr_en,
    input  logic [dkph_pkg::CFG_IDX_W-1:0]     cfg_wr_index,
    input  logic [dkph_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_HASH,
        ST_ABS,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t                              state_reg;
    logic [dkph_pkg::MAG_W-1:0]          mag_reg;
    logic                                neg_reg;
    logic [dkph_pkg::DIGIT_W-1:0]        dig_reg [dkph_pkg::NUM_DIGITS];
    logic [dkph_pkg::DIG_IDX_W-1:0]      nd_reg;
    logic [dkph_pkg::DIG_IDX_W-1:0]      idx_reg;
    logic [dkph_pkg::HASH_W-1:0]         h_reg;
    logic [dkph_pkg::HASH_W-1:0]         quo_reg;
    logic [dkph_pkg::TSIZE_W-1:0]        rem_reg;
    logic [dkph_pkg::DIV_CNT_W-1:0]      cnt_reg;
    logic                                hneg_reg;
    logic                                m_tvalid_reg;
    logic [dkph_pkg::BUCKET_W-1:0]       m_tdata_reg;
    logic [dkph_pkg::MULT_W-1:0]         mult_reg;
    logic [dkph_pkg::TSIZE_W-1:0]        tsize_reg;

    // shared multiplier
    logic [dkph_pkg::HASH_W-1:0]               mul_a;
    logic [dkph_pkg::MULT_W-1:0]               mul_b;
    logic [dkph_pkg::HASH_W+dkph_pkg::MULT_W-1:0] prod;

    logic [dkph_pkg::MAG_W-1:0]          quot10;
    logic [dkph_pkg::MAG_W-1:0]          quot10_x10;
    logic [dkph_pkg::MAG_W-1:0]          rem10_full;
    logic [dkph_pkg::DIGIT_W-1:0]        rem10;
    logic [dkph_pkg::CHAR_W-1:0]         hash_char;
    logic [dkph_pkg::HASH_W-1:0]         h_next;

    // divider step
    logic [dkph_pkg::TSIZE_W:0]          div_trial;
    logic [dkph_pkg::TSIZE_W:0]          div_diff;
    logic                                div_ge;
    logic [dkph_pkg::TSIZE_W-1:0]        rem_next;
    logic [dkph_pkg::BUCKET_W-1:0]       bucket;
    logic                                out_free;
    logic [dkph_pkg::KEY_W-1:0]          key_abs;

    always_comb begin
        if (state_reg == ST_CONV) begin
            mul_a = {{(dkph_pkg::HASH_W-dkph_pkg::MAG_W){1'b0}}, mag_reg};
            mul_b = dkph_pkg::DIV10_RECIP;
        end else begin
            mul_a = h_reg;
            mul_b = mult_reg;
        end
        prod = {{dkph_pkg::MULT_W{1'b0}}, mul_a} * {{dkph_pkg::HASH_W{1'b0}}, mul_b};
    end

    assign quot10     = prod[dkph_pkg::DIV10_SHIFT +: dkph_pkg::MAG_W];
    assign quot10_x10 = (quot10 << 3) + (quot10 << 1);
    assign rem10_full = mag_reg - quot10_x10;
    assign rem10      = rem10_full[dkph_pkg::DIGIT_W-1:0];

    assign hash_char = dkph_pkg::ASCII_ZERO
                     + {{(dkph_pkg::CHAR_W-dkph_pkg::DIGIT_W){1'b0}}, dig_reg[idx_reg]};
    assign h_next    = prod[dkph_pkg::HASH_W-1:0]
                     + {{(dkph_pkg::HASH_W-dkph_pkg::CHAR_W){1'b0}}, hash_char};

    assign div_trial = {rem_reg, quo_reg[dkph_pkg::HASH_W-1]};
    assign div_diff  = div_trial - {1'b0, tsize_reg};
    assign div_ge    = div_trial >= {1'b0, tsize_reg};
    assign rem_next  = div_ge ? div_diff[dkph_pkg::TSIZE_W-1:0]
                              : div_trial[dkph_pkg::TSIZE_W-1:0];

    always_comb begin
        if (tsize_reg == '0) begin
            bucket = '0;
        end else if (hneg_reg) begin
            bucket = {{(dkph_pkg::BUCKET_W-dkph_pkg::TSIZE_W){1'b0}}, rem_reg};
            bucket = -bucket;
        end else begin
            bucket = {{(dkph_pkg::BUCKET_W-dkph_pkg::TSIZE_W){1'b0}}, rem_reg};
        end
    end

    assign key_abs  = s_tdata[dkph_pkg::KEY_W-1] ? (~s_tdata + 1'b1) : s_tdata;
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            mult_reg     <= dkph_pkg::MULT_RESET;
            tsize_reg    <= dkph_pkg::TSIZE_RESET;
            nd_reg       <= '0;
            cnt_reg      <= '0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_wr_index == dkph_pkg::CFG_MULTIPLIER) begin
                    mult_reg <= cfg_wr_data;
                end else if (cfg_wr_index == dkph_pkg::CFG_TABLE_SIZE) begin
                    tsize_reg <= cfg_wr_data[dkph_pkg::TSIZE_W-1:0];
                end
            end

            if (m_tvalid_reg && m_tready && state_reg != ST_DONE) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        // most negative key gives 0x8000, read as 32768
                        mag_reg   <= {1'b0, key_abs};
                        neg_reg   <= s_tdata[dkph_pkg::KEY_W-1];
                        nd_reg    <= '0;
                        state_reg <= ST_CONV;
                    end
                end
                ST_CONV: begin
                    dig_reg[nd_reg] <= rem10;
                    mag_reg         <= quot10;
                    nd_reg          <= nd_reg + 1'b1;
                    if (quot10 == '0
                        || nd_reg == dkph_pkg::DIG_IDX_W'(dkph_pkg::NUM_DIGITS - 1)) begin
                        idx_reg   <= nd_reg;
                        h_reg     <= neg_reg
                            ? {{(dkph_pkg::HASH_W-dkph_pkg::CHAR_W){1'b0}},
                               dkph_pkg::ASCII_MINUS}
                            : '0;
                        state_reg <= ST_HASH;
                    end
                end
                ST_HASH: begin
                    h_reg   <= h_next;
                    idx_reg <= idx_reg - 1'b1;
                    if (idx_reg == '0) begin
                        state_reg <= ST_ABS;
                    end
                end
                ST_ABS: begin
                    hneg_reg  <= h_reg[dkph_pkg::HASH_W-1];
                    quo_reg   <= h_reg[dkph_pkg::HASH_W-1] ? (~h_reg + 1'b1) : h_reg;
                    rem_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    rem_reg <= rem_next;
                    quo_reg <= quo_reg << 1;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == '1) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= bucket;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // an accepted key keeps the input closed on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken again right after a transfer");

    // at most five digits are ever produced
    assert property (@(posedge aclk) disable iff (!aresetn)
        nd_reg <= dkph_pkg::DIG_IDX_W'(dkph_pkg::NUM_DIGITS))
        else $error("digit count overflow");

    // each produced digit is a decimal digit
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CONV) |-> (rem10_full < dkph_pkg::MAG_W'(10)))
        else $error("digit split out of range");

    // partial remainder stays below the divisor
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && tsize_reg != '0) |-> (rem_reg < tsize_reg))
        else $error("divider remainder out of range");

    // a waiting result stays valid until it is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("pending result dropped");

endmodule
